@@ rtl/core/ftlb_pkg.sv @@
// ----------------------------------------------------------------------------
// ftlb_pkg
// Shared types and constants for the FIFO-replacement TLB with pid tags.
// ----------------------------------------------------------------------------
package ftlb_pkg;

	localparam int DEPTH    = 16;
	localparam int PID_BITS = 16;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int PADDR_W  = 5;
	localparam int REG_W    = 3;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_INVAL  = 2'd2,
		OP_DIRTY  = 2'd3
	} op_t;

	localparam logic [REG_W-1:0] REG_OFFSET = 3'd0;
	localparam logic [REG_W-1:0] REG_GLOBAL = 3'd1;
	localparam logic [REG_W-1:0] REG_FRAME  = 3'd2;
	localparam logic [REG_W-1:0] REG_DIRTY  = 3'd3;
	localparam logic [REG_W-1:0] REG_WSET   = 3'd4;

	localparam logic [4:0]  RST_OFFSET = 5'd12;
	localparam logic [31:0] RST_GLOBAL = 32'h0000_0100;
	localparam logic [31:0] RST_FRAME  = 32'hFFFF_F000;
	localparam logic [31:0] RST_DIRTY  = 32'h0000_0040;
	localparam logic [31:0] RST_WSET   = 32'h0000_0020;

	typedef struct packed {
		logic [4:0]  offset_bits;
		logic [31:0] shared_mask;
		logic [31:0] frame_mask;
		logic [31:0] modify_mask;
		logic [31:0] working_set_mask;
	} cfg_t;

	typedef struct packed {
		logic latch;
		logic exec;
	} cmd_t;

	// first set bit in queue order, queue starting at slot oldest
	function automatic logic [DEPTH-1:0] pick_oldest(input logic [DEPTH-1:0] vec,
		input logic [IDX_W-1:0] oldest);
		logic [DEPTH-1:0] upper;
		logic [DEPTH-1:0] hi;
		logic [DEPTH-1:0] lo;
		logic [DEPTH-1:0] sel;
		for (int i = 0; i < DEPTH; i++) begin
			upper[i] = (IDX_W'(i) >= oldest);
		end
		hi  = vec & upper;
		lo  = vec & ~upper;
		sel = (hi != '0) ? hi : lo;
		return sel & (~sel + DEPTH'(1));
	endfunction

endpackage

@@ rtl/core/fifo_tlb_with_pid_tags_top.sv @@
// ----------------------------------------------------------------------------
// fifo_tlb_with_pid_tags_top
// Fully associative TLB, oldest-first replacement, per-process tags.
// ----------------------------------------------------------------------------
// Result: a request accepted while idle runs in the execute state, and its
// result strobe (done) is registered from it; the receiver cannot stall and takes it then.
// Busy: no new request is taken during the single execute state of the entry
// compare and write-back; busy is high during that state.
// Reset: queue empties and registers take their defaults; entry contents
// are not cleared, so no clearing pass is needed.
module fifo_tlb_with_pid_tags_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    operation,
	input  logic [ftlb_pkg::PID_BITS-1:0] requester_pid,
	input  logic [31:0]                   virt_addr,
	input  logic [31:0]                   new_table_entry,
	input  logic [31:0]                   dirty_frame,
	output logic                          done,
	output logic                          hit,
	output logic                          miss,
	output logic [31:0]                   frame_number,
	output logic                          evict_valid,
	output logic [31:0]                   evict_frame,
	output logic [31:0]                   evict_table_entry,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ftlb_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import ftlb_pkg::*;

	cfg_t cfg;
	cmd_t cmd;

	ftlb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ftlb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	ftlb_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.cfg               (cfg),
		.operation         (operation),
		.requester_pid     (requester_pid),
		.virt_addr         (virt_addr),
		.new_table_entry   (new_table_entry),
		.dirty_frame       (dirty_frame),
		.done              (done),
		.hit               (hit),
		.miss              (miss),
		.frame_number      (frame_number),
		.evict_valid       (evict_valid),
		.evict_frame       (evict_frame),
		.evict_table_entry (evict_table_entry)
	);

endmodule

@@ rtl/core/ftlb_cfg.sv @@
// ----------------------------------------------------------------------------
// ftlb_cfg
// APB-style configuration registers.
// ----------------------------------------------------------------------------
module ftlb_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ftlb_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output ftlb_pkg::cfg_t                cfg
);
	import ftlb_pkg::*;

	cfg_t             cfg_q;
	logic             wr_en;
	logic [REG_W-1:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[PADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_bits      <= RST_OFFSET;
			cfg_q.shared_mask      <= RST_GLOBAL;
			cfg_q.frame_mask       <= RST_FRAME;
			cfg_q.modify_mask      <= RST_DIRTY;
			cfg_q.working_set_mask <= RST_WSET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_OFFSET: cfg_q.offset_bits      <= pwdata[4:0];
				REG_GLOBAL: cfg_q.shared_mask      <= pwdata;
				REG_FRAME:  cfg_q.frame_mask       <= pwdata;
				REG_DIRTY:  cfg_q.modify_mask      <= pwdata;
				REG_WSET:   cfg_q.working_set_mask <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_OFFSET: prdata = {27'd0, cfg_q.offset_bits};
			REG_GLOBAL: prdata = cfg_q.shared_mask;
			REG_FRAME:  prdata = cfg_q.frame_mask;
			REG_DIRTY:  prdata = cfg_q.modify_mask;
			REG_WSET:   prdata = cfg_q.working_set_mask;
			default:    prdata = 32'd0;
		endcase
	end

endmodule

@@ rtl/core/ftlb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ftlb_ctrl
// Request sequencer: latch a request, then execute it in the execute state.
// ----------------------------------------------------------------------------
module ftlb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output ftlb_pkg::cmd_t cmd
);
	import ftlb_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		case (state_q)
			ST_IDLE: state_nxt = start ? ST_EXEC : ST_IDLE;
			ST_EXEC: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy      = (state_q == ST_EXEC);
	assign cmd.latch = start & (state_q == ST_IDLE);
	assign cmd.exec  = (state_q == ST_EXEC);

endmodule

@@ rtl/core/ftlb_dp.sv @@
// ----------------------------------------------------------------------------
// ftlb_dp
// Entry registers, parallel tag compare, oldest-first pick and result regs.
// ----------------------------------------------------------------------------
module ftlb_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ftlb_pkg::cmd_t                cmd,
	input  ftlb_pkg::cfg_t                cfg,
	input  logic [1:0]                    operation,
	input  logic [ftlb_pkg::PID_BITS-1:0] requester_pid,
	input  logic [31:0]                   virt_addr,
	input  logic [31:0]                   new_table_entry,
	input  logic [31:0]                   dirty_frame,
	output logic                          done,
	output logic                          hit,
	output logic                          miss,
	output logic [31:0]                   frame_number,
	output logic                          evict_valid,
	output logic [31:0]                   evict_frame,
	output logic [31:0]                   evict_table_entry
);
	import ftlb_pkg::*;

	// request registers
	op_t                 op_q;
	logic [PID_BITS-1:0] pid_q;
	logic [31:0]         page_q;
	logic [31:0]         pte_q;
	logic [31:0]         dframe_q;

	// entry store
	logic                slot_valid  [DEPTH];
	logic                slot_global [DEPTH];
	logic [PID_BITS-1:0] slot_pid    [DEPTH];
	logic [31:0]         slot_page   [DEPTH];
	logic [31:0]         slot_frame  [DEPTH];
	logic [31:0]         slot_entry  [DEPTH];

	logic [IDX_W-1:0] oldest_q;
	logic [CNT_W-1:0] count_q;

	logic                done_q, hit_q, miss_q, ev_valid_q;
	logic [31:0]         frame_q, ev_frame_q, ev_entry_q;

	logic [DEPTH-1:0] occ, lk_vec, inv_vec, dt_vec, search_vec, pick_oh, old_oh, wr_oh;
	logic [31:0]      pick_frame, old_frame, old_entry;
	logic             any_match, full, new_global;
	logic [CNT_W:0]   wr_sum;
	logic [IDX_W-1:0] wr_idx, oldest_inc;

	always_comb begin
		logic [CNT_W-1:0] pos;
		for (int i = 0; i < DEPTH; i++) begin
			if (IDX_W'(i) >= oldest_q) begin
				pos = CNT_W'(i) - CNT_W'(oldest_q);
			end else begin
				pos = CNT_W'(i) + CNT_W'(DEPTH) - CNT_W'(oldest_q);
			end
			occ[i]     = (pos < count_q);
			lk_vec[i]  = occ[i] & slot_valid[i] & (slot_page[i] == page_q) &
				(slot_global[i] | (slot_pid[i] == pid_q));
			inv_vec[i] = occ[i] & ~slot_global[i] & (slot_pid[i] == pid_q);
			dt_vec[i]  = occ[i] & slot_valid[i] & (slot_frame[i] == dframe_q);
			old_oh[i]  = (IDX_W'(i) == oldest_q);
			wr_oh[i]   = (IDX_W'(i) == wr_idx);
		end
	end

	assign search_vec = (op_q == OP_LOOKUP) ? lk_vec : dt_vec;
	assign pick_oh    = pick_oldest(search_vec, oldest_q);
	assign any_match  = |search_vec;
	assign full       = (count_q == CNT_W'(DEPTH));
	assign new_global = (pte_q & cfg.shared_mask) != 32'd0;

	always_comb begin
		pick_frame = '0;
		old_frame  = '0;
		old_entry  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			pick_frame = pick_frame | (slot_frame[i] & {32{pick_oh[i]}});
			old_frame  = old_frame  | (slot_frame[i] & {32{old_oh[i]}});
			old_entry  = old_entry  | (slot_entry[i] & {32{old_oh[i]}});
		end
	end

	// append position: oldest + count, wrapped
	always_comb begin
		wr_sum = {1'b0, CNT_W'(oldest_q)} + {1'b0, count_q};
		if (full) begin
			wr_idx = oldest_q;
		end else if (wr_sum >= (CNT_W + 1)'(DEPTH)) begin
			wr_idx = IDX_W'(wr_sum - (CNT_W + 1)'(DEPTH));
		end else begin
			wr_idx = IDX_W'(wr_sum);
		end
		oldest_inc = (oldest_q == IDX_W'(DEPTH - 1)) ? '0 : oldest_q + IDX_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q     <= op_t'(operation);
			pid_q    <= requester_pid;
			page_q   <= virt_addr >> cfg.offset_bits;
			pte_q    <= new_table_entry;
			dframe_q <= dirty_frame;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < DEPTH; i++) begin
				case (op_q)
					OP_LOOKUP: begin
						if (pick_oh[i]) begin
							slot_entry[i] <= slot_entry[i] | cfg.working_set_mask;
						end
					end
					OP_INSERT: begin
						if (wr_oh[i]) begin
							slot_valid[i]  <= 1'b1;
							slot_global[i] <= new_global;
							slot_pid[i]    <= new_global ? '1 : pid_q;
							slot_page[i]   <= page_q;
							slot_frame[i]  <= pte_q & cfg.frame_mask;
							slot_entry[i]  <= pte_q;
						end
					end
					OP_INVAL: begin
						if (inv_vec[i]) begin
							slot_valid[i] <= 1'b0;
						end
					end
					OP_DIRTY: begin
						if (pick_oh[i]) begin
							slot_entry[i] <= slot_entry[i] | cfg.modify_mask;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q   <= '0;
			count_q    <= '0;
			done_q     <= 1'b0;
			hit_q      <= 1'b0;
			miss_q     <= 1'b0;
			frame_q    <= '0;
			ev_valid_q <= 1'b0;
			ev_frame_q <= '0;
			ev_entry_q <= '0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec) begin
				hit_q      <= 1'b0;
				miss_q     <= 1'b0;
				frame_q    <= '0;
				ev_valid_q <= 1'b0;
				ev_frame_q <= '0;
				ev_entry_q <= '0;
				case (op_q)
					OP_LOOKUP: begin
						hit_q   <= any_match;
						miss_q  <= ~any_match;
						frame_q <= any_match ? pick_frame : '1;
					end
					OP_INSERT: begin
						if (full) begin
							ev_valid_q <= 1'b1;
							ev_frame_q <= old_frame;
							ev_entry_q <= old_entry;
							oldest_q   <= oldest_inc;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign done              = done_q;
	assign hit               = hit_q;
	assign miss              = miss_q;
	assign frame_number      = frame_q;
	assign evict_valid       = ev_valid_q;
	assign evict_frame       = ev_frame_q;
	assign evict_table_entry = ev_entry_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("occupancy above depth");

	a_done_follows_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> done_q)
		else $error("result strobe missing after execute");

	a_hit_miss_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(hit_q && miss_q))
		else $error("hit and miss both set");

	a_evict_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && op_q == OP_INSERT && full) |=> (ev_valid_q && count_q == CNT_W'(DEPTH)))
		else $error("full insert did not evict");

endmodule

@@ tb/sv/ftlb_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ftlb_tb_pkg
// Shadow copy of the FIFO TLB for the testbench. It tracks the slot queue and
// registers, works out the reply for each accepted request and checks replies
// in order as they come back from the block.
// ----------------------------------------------------------------------------
package ftlb_tb_pkg;

	import ftlb_pkg::*;

	typedef struct packed {
		logic        hit;
		logic        miss;
		logic [31:0] frame_number;
		logic        evict_valid;
		logic [31:0] evict_frame;
		logic [31:0] evict_table_entry;
	} tlb_reply_t;

	class shadow_tlb;
		logic [4:0]          offset_bits;
		logic [31:0]         shared_mask;
		logic [31:0]         frame_mask;
		logic [31:0]         modify_mask;
		logic [31:0]         working_set_mask;
		bit                  slot_live   [DEPTH];
		bit                  slot_shared [DEPTH];
		logic [PID_BITS-1:0] slot_owner  [DEPTH];
		logic [31:0]         slot_vpage  [DEPTH];
		logic [31:0]         slot_pframe [DEPTH];
		logic [31:0]         slot_pte    [DEPTH];
		int unsigned         head;
		int unsigned         fill;
		tlb_reply_t          due_replies[$];
		int unsigned         mismatches;

		function new();
			offset_bits      = RST_OFFSET;
			shared_mask      = RST_GLOBAL;
			frame_mask       = RST_FRAME;
			modify_mask      = RST_DIRTY;
			working_set_mask = RST_WSET;
			head             = 0;
			fill             = 0;
			mismatches       = 0;
		endfunction

		function void set_register(input logic [REG_W-1:0] idx, input logic [31:0] value);
			case (idx)
				REG_OFFSET: offset_bits      = value[4:0];
				REG_GLOBAL: shared_mask      = value;
				REG_FRAME:  frame_mask       = value;
				REG_DIRTY:  modify_mask      = value;
				REG_WSET:   working_set_mask = value;
				default: ;
			endcase
		endfunction

		function logic [31:0] register_value(input logic [REG_W-1:0] idx);
			case (idx)
				REG_OFFSET: return {27'd0, offset_bits};
				REG_GLOBAL: return shared_mask;
				REG_FRAME:  return frame_mask;
				REG_DIRTY:  return modify_mask;
				REG_WSET:   return working_set_mask;
				default:    return 32'd0;
			endcase
		endfunction

		task report(input string msg);
			$display("ERROR @%0t: %s", $realtime, msg);
			mismatches++;
		endtask

		// queue position 0 is the oldest slot
		function void accept_request(input op_t op, input logic [PID_BITS-1:0] pid,
			input logic [31:0] addr, input logic [31:0] pte, input logic [31:0] dframe);
			tlb_reply_t  r;
			logic [31:0] page;
			int unsigned s;
			bit          found;
			r     = '0;
			page  = addr >> offset_bits;
			found = 0;
			case (op)
				OP_LOOKUP: begin
					for (int i = 0; i < fill && !found; i++) begin
						s = (head + i) % DEPTH;
						if (slot_live[s] && slot_vpage[s] == page &&
							(slot_shared[s] || slot_owner[s] == pid)) begin
							slot_pte[s]    |= working_set_mask;
							r.hit          = 1'b1;
							r.frame_number = slot_pframe[s];
							found          = 1;
						end
					end
					if (!found) begin
						r.miss         = 1'b1;
						r.frame_number = '1;
					end
				end
				OP_INSERT: begin
					if (fill == DEPTH) begin
						r.evict_valid       = 1'b1;
						r.evict_frame       = slot_pframe[head];
						r.evict_table_entry = slot_pte[head];
						head                = (head + 1) % DEPTH;
						fill                = DEPTH - 1;
					end
					s              = (head + fill) % DEPTH;
					slot_live[s]   = 1;
					slot_shared[s] = (pte & shared_mask) != 0;
					slot_owner[s]  = slot_shared[s] ? '1 : pid;
					slot_vpage[s]  = page;
					slot_pframe[s] = pte & frame_mask;
					slot_pte[s]    = pte;
					fill++;
				end
				OP_INVAL: begin
					for (int i = 0; i < fill; i++) begin
						s = (head + i) % DEPTH;
						if (!slot_shared[s] && slot_owner[s] == pid)
							slot_live[s] = 0;
					end
				end
				default: begin
					for (int i = 0; i < fill && !found; i++) begin
						s = (head + i) % DEPTH;
						if (slot_live[s] && slot_pframe[s] == dframe) begin
							slot_pte[s] |= modify_mask;
							found       = 1;
						end
					end
				end
			endcase
			due_replies.push_back(r);
		endfunction

		task check_reply(input tlb_reply_t got);
			tlb_reply_t want;
			if (due_replies.size() == 0) begin
				report("reply strobe with no request outstanding");
			end else begin
				want = due_replies.pop_front();
				if (got.hit !== want.hit)
					report($sformatf("hit got %b want %b", got.hit, want.hit));
				if (got.miss !== want.miss)
					report($sformatf("miss got %b want %b", got.miss, want.miss));
				if (got.frame_number !== want.frame_number)
					report($sformatf("frame_number got %h want %h",
						got.frame_number, want.frame_number));
				if (got.evict_valid !== want.evict_valid)
					report($sformatf("evict_valid got %b want %b",
						got.evict_valid, want.evict_valid));
				if (got.evict_frame !== want.evict_frame)
					report($sformatf("evict_frame got %h want %h",
						got.evict_frame, want.evict_frame));
				if (got.evict_table_entry !== want.evict_table_entry)
					report($sformatf("evict_table_entry got %h want %h",
						got.evict_table_entry, want.evict_table_entry));
			end
		endtask
	endclass

endpackage

@@ tb/sv/tb_fifo_tlb_with_pid_tags_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fifo_tlb_with_pid_tags_top
// Drives lookups, inserts, pid invalidates and dirty marks into the TLB under
// several register settings and idle patterns, and checks every reply
// against the shadow TLB. Register writes are read back over the same port.
// ----------------------------------------------------------------------------
module tb_fifo_tlb_with_pid_tags_top;

	import ftlb_pkg::*;
	import ftlb_tb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 225;

	typedef struct {
		logic [PID_BITS-1:0] pid;
		logic [31:0]         addr;
		logic [31:0]         pte;
	} mapping_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          operation;
	logic [PID_BITS-1:0] requester_pid;
	logic [31:0]         virt_addr;
	logic [31:0]         new_table_entry;
	logic [31:0]         dirty_frame;
	logic                done;
	logic                hit;
	logic                miss;
	logic [31:0]         frame_number;
	logic                evict_valid;
	logic [31:0]         evict_frame;
	logic [31:0]         evict_table_entry;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	shadow_tlb   sb;
	mapping_t    mappings[$];
	int unsigned cycle_count;

	fifo_tlb_with_pid_tags_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.operation         (operation),
		.requester_pid     (requester_pid),
		.virt_addr         (virt_addr),
		.new_table_entry   (new_table_entry),
		.dirty_frame       (dirty_frame),
		.done              (done),
		.hit               (hit),
		.miss              (miss),
		.frame_number      (frame_number),
		.evict_valid       (evict_valid),
		.evict_frame       (evict_frame),
		.evict_table_entry (evict_table_entry),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_reply('{hit, miss, frame_number, evict_valid, evict_frame,
				evict_table_entry});
	end

	task automatic send_request(input op_t op, input logic [PID_BITS-1:0] pid,
		input logic [31:0] addr, input logic [31:0] pte, input logic [31:0] dframe);
		start           = 1'b1;
		operation       = op;
		requester_pid   = pid;
		virt_addr       = addr;
		new_table_entry = pte;
		dirty_frame     = dframe;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.accept_request(op, pid, addr, pte, dframe);
		if (op == OP_INSERT) begin
			mappings.push_back('{pid, addr, pte});
			if (mappings.size() > 32)
				void'(mappings.pop_front());
		end
		@(negedge clk);
	endtask

	task automatic wait_idle();
		start = 1'b0;
		while (sb.due_replies.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input logic [REG_W-1:0] idx, input logic [31:0] value);
		logic [31:0] readback;
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_register(idx, value);
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		readback = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (readback !== sb.register_value(idx))
			sb.report($sformatf("register %0d read %h want %h", idx, readback,
				sb.register_value(idx)));
	endtask

	function automatic logic [PID_BITS-1:0] pick_pid();
		case ($urandom_range(5))
			0:       return '0;
			1:       return PID_BITS'(1);
			2:       return PID_BITS'(16'h7FFF);
			3:       return '1;
			default: return PID_BITS'($urandom);
		endcase
	endfunction

	// mostly well-formed traffic around recent inserts, some pure noise
	task automatic random_request();
		int unsigned         roll;
		mapping_t            m;
		logic [PID_BITS-1:0] pid;
		logic [31:0]         addr;
		logic [31:0]         low_bits;
		logic [31:0]         dframe;
		roll     = $urandom_range(99);
		pid      = pick_pid();
		addr     = $urandom;
		dframe   = $urandom;
		low_bits = (32'd1 << sb.offset_bits) - 32'd1;
		if (mappings.size() != 0)
			m = mappings[$urandom_range(mappings.size() - 1)];
		else
			m = '{pid, addr, $urandom};
		if (roll < 12) begin
			send_request(op_t'($urandom_range(3)), PID_BITS'($urandom), $urandom,
				$urandom, $urandom);
		end else if (roll < 42) begin
			send_request(OP_INSERT, pid, addr, $urandom, dframe);
		end else if (roll < 77) begin
			if ($urandom_range(9) < 8) begin
				addr = m.addr ^ ($urandom & low_bits);
				if ($urandom_range(9) < 7)
					pid = m.pid;
			end
			send_request(OP_LOOKUP, pid, addr, $urandom, dframe);
		end else if (roll < 87) begin
			if ($urandom_range(9) < 8)
				dframe = m.pte & sb.frame_mask;
			send_request(OP_DIRTY, pid, addr, $urandom, dframe);
		end else begin
			if ($urandom_range(1) == 0)
				pid = m.pid;
			send_request(OP_INVAL, pid, addr, $urandom, dframe);
		end
	endtask

	task automatic run_phase(input logic [4:0] off, input logic [31:0] glob,
		input logic [31:0] fmask, input logic [31:0] dmask, input logic [31:0] wmask,
		input int unsigned idle_pct);
		wait_idle();
		write_register(REG_OFFSET, {27'd0, off});
		write_register(REG_GLOBAL, glob);
		write_register(REG_FRAME, fmask);
		write_register(REG_DIRTY, dmask);
		write_register(REG_WSET, wmask);
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if ($urandom_range(99) == 0)
				wait_idle();
			while ($urandom_range(99) < idle_pct) begin
				start = 1'b0;
				@(negedge clk);
			end
			random_request();
		end
	endtask

	initial begin
		sb              = new();
		cycle_count     = 0;
		arst_n          = 1'b0;
		start           = 1'b0;
		operation       = OP_LOOKUP;
		requester_pid   = '0;
		virt_addr       = '0;
		new_table_entry = '0;
		dirty_frame     = '0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty table, own/global/foreign pid, dirty, invalidate, eviction
		send_request(OP_LOOKUP, '0, 32'h0000_0000, '0, '0);
		send_request(OP_INSERT, PID_BITS'(1), 32'h0000_1000, 32'h0000_5003, '0);
		send_request(OP_INSERT, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
		send_request(OP_LOOKUP, PID_BITS'(1), 32'h0000_1ABC, '0, '0);
		send_request(OP_LOOKUP, PID_BITS'(16'h1234), 32'hFFFF_F000, '0, '0);
		send_request(OP_LOOKUP, PID_BITS'(2), 32'h0000_1000, '0, '0);
		send_request(OP_DIRTY, PID_BITS'(1), '0, '0, 32'h0000_5000);
		send_request(OP_DIRTY, PID_BITS'(1), '0, '0, 32'h1234_5000);
		send_request(OP_INVAL, PID_BITS'(1), '0, '0, '0);
		send_request(OP_LOOKUP, PID_BITS'(1), 32'h0000_1000, '0, '0);
		for (int i = 0; i < 15; i++)
			send_request(OP_INSERT, PID_BITS'(1), 32'(i) << 12,
				32'h0010_0000 | (32'(i) << 12) | 32'h3, '0);
		send_request(OP_LOOKUP, PID_BITS'(1), 32'h0000_1FFF, '0, '0);

		run_phase(5'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 29);
		run_phase(5'd31, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 29);
		run_phase(5'($urandom_range(1, 30)), 32'd1 << $urandom_range(31), $urandom,
			$urandom, $urandom, 57);
		run_phase(5'd20, 32'h0000_0200, 32'hFFF0_0000, 32'h0000_0001, 32'h0000_0002, 57);
		run_phase(5'($urandom_range(1, 30)), 32'd1 << $urandom_range(31), $urandom,
			$urandom, $urandom, 0);
		run_phase(RST_OFFSET, RST_GLOBAL, RST_FRAME, RST_DIRTY, RST_WSET, 0);

		wait_idle();
		if (sb.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
